### hdl/smf_pkg.sv
// Shared types and fixed field widths for the sorted median finder.
`default_nettype none

package smf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MED_W    = 17;
    localparam int CNT_W    = 6;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_req;

    typedef struct packed {
        logic signed [MED_W-1:0] median_times_two;
        logic [CNT_W-1:0]        count;
        logic                    overflow;
    } t_rsp;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;    // insert the broadcast sample in sorted position
        logic shift;  // move every value one cell toward cell 0
        logic clear;  // drop all occupancy
    } t_cell_ctl;

endpackage

`default_nettype wire

### hdl/smf_cell.sv
// One cell of the insertion-sort chain: holds one sorted value and its occupancy.
`default_nettype none

module smf_cell
    import smf_pkg::*;
#(
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_cell_ctl                    i_ctl,
    input  wire logic signed [DATA_WIDTH-1:0] i_sample,
    input  wire logic signed [DATA_WIDTH-1:0] i_left_val,
    input  wire logic                         i_left_occ,
    input  wire logic                         i_left_gt,
    input  wire logic signed [DATA_WIDTH-1:0] i_right_val,
    output logic signed [DATA_WIDTH-1:0]      o_val,
    output logic                              o_occ,
    output logic                              o_gt
);

    logic signed [DATA_WIDTH-1:0] r_val, n_val;
    logic                         r_occ, n_occ;

    assign o_val = r_val;
    assign o_occ = r_occ;
    assign o_gt  = r_occ && (r_val > i_sample);

    always_comb begin
        n_val = r_val;
        n_occ = r_occ;
        if (i_ctl.clear) begin
            n_occ = 1'b0;
        end else if (i_ctl.shift) begin
            n_val = i_right_val;
        end else if (i_ctl.ins) begin
            n_occ = r_occ | i_left_occ;
            // larger values move up one cell; the first larger (or first empty) cell takes the new one
            if (i_left_gt) begin
                n_val = i_left_val;
            end else if (o_gt || (!r_occ && i_left_occ)) begin
                n_val = i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

### hdl/sorted_median_finder.sv
// Top level: sorting cell chain, drain control and result register.
//
//  channel  | direction | handshake               | payload
//  request  | in        | i_in_valid / o_in_ready | i_in_req  (t_req: sample, last)
//  result   | out       | o_out_valid / i_out_ready | o_out_rsp (t_rsp: median, count, overflow)
//
// While o_in_ready is high a sample is taken every cycle and sorted on arrival, or
// dropped with overflow set if the store is full. After a request with last, the
// chain drains toward cell 0 while o_in_ready is low; the median is then loaded into
// the result register and requests are taken again while the result waits. Result
// stalls hold the last drain step. Reset clears occupancy, counts and state.
`default_nettype none

module sorted_median_finder
    import smf_pkg::*;
#(
    parameter int MAX_COUNT  = 32,
    parameter int DATA_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in_req,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_rsp      o_out_rsp
);

    localparam int CW = $clog2(MAX_COUNT + 1);
    localparam int SW = DATA_WIDTH + 1;

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_FIND    = 1'b1;

    logic                         r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic                         r_dropped, n_dropped;
    logic [CW-1:0]                r_idx, n_idx;
    logic signed [DATA_WIDTH-1:0] r_lo, n_lo;
    logic                         r_out_valid, n_out_valid;
    t_rsp                         r_rsp, n_rsp;

    logic signed [DATA_WIDTH-1:0] w_sample;
    logic signed [DATA_WIDTH-1:0] w_val [MAX_COUNT];
    logic                         w_occ [MAX_COUNT];
    logic                         w_gt  [MAX_COUNT];
    t_cell_ctl                    w_ctl;

    logic                         w_accept;
    logic                         w_full;
    logic                         w_out_free;
    logic [CW-1:0]                w_lo_idx;
    logic [CW-1:0]                w_hi_idx;
    logic signed [SW-1:0]         w_sum;

    assign w_sample   = DATA_WIDTH'(i_in_req.sample);
    assign o_in_ready = (r_state == ST_COLLECT);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CW'(MAX_COUNT));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_lo_idx   = (r_count - CW'(1)) >> 1;
    assign w_hi_idx   = r_count >> 1;

    // odd count: both middle indexes coincide at cell 0 this cycle
    assign w_sum = (w_lo_idx == w_hi_idx) ? (SW'(w_val[0]) + SW'(w_val[0]))
                                          : (SW'(r_lo) + SW'(w_val[0]));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_idx       = r_idx;
        n_lo        = r_lo;
        n_out_valid = r_out_valid && !i_out_ready;
        n_rsp       = r_rsp;
        w_ctl       = '0;
        case (r_state)
            ST_COLLECT: begin
                if (w_accept) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + CW'(1);
                    end
                    if (i_in_req.last) begin
                        n_state = ST_FIND;
                        n_idx   = '0;
                    end
                end
            end
            ST_FIND: begin
                if (r_idx == w_lo_idx) begin
                    n_lo = w_val[0];
                end
                if (r_idx != w_hi_idx) begin
                    w_ctl.shift = 1'b1;
                    n_idx       = r_idx + CW'(1);
                end else if (w_out_free) begin
                    n_out_valid            = 1'b1;
                    n_rsp.median_times_two = MED_W'(w_sum);
                    n_rsp.count            = CNT_W'(r_count);
                    n_rsp.overflow         = r_dropped;
                    w_ctl.clear            = 1'b1;
                    n_count                = '0;
                    n_dropped              = 1'b0;
                    n_state                = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_rsp <= n_rsp;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

    for (genvar g = 0; g < MAX_COUNT; g++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] w_left_val;
        logic signed [DATA_WIDTH-1:0] w_right_val;
        logic                         w_left_occ;
        logic                         w_left_gt;

        if (g == 0) begin : g_head
            assign w_left_val = w_sample;
            assign w_left_occ = 1'b1;
            assign w_left_gt  = 1'b0;
        end else begin : g_body
            assign w_left_val = w_val[g-1];
            assign w_left_occ = w_occ[g-1];
            assign w_left_gt  = w_gt[g-1];
        end

        if (g == MAX_COUNT - 1) begin : g_tail
            assign w_right_val = w_val[g];
        end else begin : g_mid
            assign w_right_val = w_val[g+1];
        end

        smf_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_sample    (w_sample),
            .i_left_val  (w_left_val),
            .i_left_occ  (w_left_occ),
            .i_left_gt   (w_left_gt),
            .i_right_val (w_right_val),
            .o_val       (w_val[g]),
            .o_occ       (w_occ[g]),
            .o_gt        (w_gt[g])
        );
    end

endmodule

`default_nettype wire

### hdl/smf_checker.sv
// Port-level checks for the sorted median finder, bound to the top level.
`default_nettype none

module smf_checker
    import smf_pkg::*;
#(
    parameter int MAX_COUNT = 32
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire t_req i_in_req,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_rsp o_out_rsp
);

    // a waiting result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("result changed while stalled");

    // a request that does not close a set never raises a result
    a_no_early_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_req.last && !o_out_valid |=> !o_out_valid)
        else $error("result without closing request");

    // the chain drains after a closing request, so input stalls next cycle
    a_drain_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_req.last |=> !o_in_ready)
        else $error("request taken during drain");

    // overflow only with a full store
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.overflow |-> o_out_rsp.count == CNT_W'(MAX_COUNT))
        else $error("overflow with store not full");

endmodule

bind sorted_median_finder smf_checker #(
    .MAX_COUNT (MAX_COUNT)
) u_smf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_rsp   (o_out_rsp)
);

`default_nettype wire
